// ===== src/tspp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspp_pkg
// Shared types and constants of the transport stream packet byte parser.
// ----------------------------------------------------------------------------
package tspp_pkg;

    // Bytes per packet, 188 for plain packets.
    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = $clog2(PACKET_BYTES);

    localparam int HDR_BYTES    = 4;
    localparam int PAYLOAD_MAX  = 184;
    localparam int PAYLOAD_END  = HDR_BYTES + PAYLOAD_MAX;
    localparam int ADAPT_MAX    = 183;

    localparam int TDATA_W = 48;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_ADAPT   = 2'd1,
        KIND_PAYLOAD = 2'd2
    } t_kind;

    // Adaptation field control codes.
    localparam logic [1:0] AFC_PAYLOAD = 2'd1;
    localparam logic [1:0] AFC_BOTH    = 2'd3;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  sync_byte;
        logic        transport_error;
        logic        unit_start;
        logic        priority_bit;
        logic [12:0] packet_id;
        logic [1:0]  scrambling;
        logic [1:0]  field_control;
        logic [3:0]  continuity;
        logic [7:0]  adapt_length;
        logic [7:0]  data_byte;
        logic        last_in_packet;
    } t_result;

endpackage
`default_nettype wire

// ===== src/ts_packet_byte_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ts_packet_byte_parser
// Transport stream packet parser taking one stream byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the result side keeps up, and the
// first byte after reset must be the first byte of a packet. Each byte is
// decoded in the cycle it is accepted against the position counter and header
// state, and its result is registered in the output stage. A two-entry
// output register lets the input take one more byte in the first cycle that
// the output is stalled; after that the input is held off until the held
// result has moved up. Byte 3 yields the header result, byte 5 (or byte 4
// for an empty adaptation field) the adaptation result, and every payload
// byte a payload result, with tlast set on the byte at the last payload
// position of the packet.
// ----------------------------------------------------------------------------
module ts_packet_byte_parser (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    input  wire  [7:0]                    i_s_tdata,   // stream_byte
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    // sync_byte, transport_error, unit_start, priority_bit, packet_id,
    // scrambling, field_control, continuity, adapt_length, data_byte
    output logic [tspp_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic [tspp_pkg::TUSER_W-1:0]  o_m_tuser,   // kind
    output logic                          o_m_tlast    // last_in_packet
);

    logic              w_accept;
    logic              w_res_valid;
    tspp_pkg::t_result w_res;
    tspp_pkg::t_result w_out;

    assign w_accept = i_s_tvalid && o_s_tready;

    tspp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_s_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    tspp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_res_valid),
        .i_res   (w_res),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_res   (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {w_out.data_byte, w_out.adapt_length, w_out.continuity,
                        w_out.field_control, w_out.scrambling, w_out.packet_id,
                        w_out.priority_bit, w_out.unit_start, w_out.transport_error,
                        w_out.sync_byte};
    assign o_m_tuser = w_out.kind;
    assign o_m_tlast = w_out.last_in_packet;

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == tspp_pkg::KIND_PAYLOAD))
        else $error("tlast set on a non-payload transfer");

endmodule
`default_nettype wire

// ===== src/tspp_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspp_decode
// Packet position counter, header and adaptation state, and the per-byte
// decode that forms at most one result for each accepted byte.
// ----------------------------------------------------------------------------
module tspp_decode (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  wire  [7:0]             i_byte,
    output logic                   o_res_valid,
    output tspp_pkg::t_result      o_res
);

    localparam logic [tspp_pkg::POS_W-1:0] LAST_POS =
        tspp_pkg::POS_W'(tspp_pkg::PACKET_BYTES - 1);
    localparam logic [7:0] PAYLOAD_END_B = 8'(tspp_pkg::PAYLOAD_END);
    localparam logic [7:0] ADAPT_MAX_B   = 8'(tspp_pkg::ADAPT_MAX);
    localparam logic [7:0] HDR_BYTES_B   = 8'(tspp_pkg::HDR_BYTES);

    logic [tspp_pkg::POS_W-1:0] r_pos,    n_pos;
    logic [23:0]                r_hdr,    n_hdr;
    logic [1:0]                 r_ctrl,   n_ctrl;
    logic [7:0]                 r_alen,   n_alen;
    logic [7:0]                 r_pstart, n_pstart;

    logic [31:0] w_word;
    logic [7:0]  w_pos8;
    logic [7:0]  w_sat;

    assign w_word = {r_hdr, i_byte};
    assign w_pos8 = 8'(r_pos);
    assign w_sat  = (i_byte > ADAPT_MAX_B) ? ADAPT_MAX_B : i_byte;

    always_comb begin
        n_pos       = r_pos;
        n_hdr       = r_hdr;
        n_ctrl      = r_ctrl;
        n_alen      = r_alen;
        n_pstart    = r_pstart;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = tspp_pkg::KIND_HEADER;

        if (w_pos8 < 8'd3) begin
            n_hdr = {r_hdr[15:0], i_byte};
        end else if (w_pos8 == 8'd3) begin
            n_ctrl   = w_word[5:4];
            n_alen   = 8'd0;
            n_pstart = (w_word[5:4] == tspp_pkg::AFC_PAYLOAD) ? HDR_BYTES_B : PAYLOAD_END_B;
            o_res_valid           = 1'b1;
            o_res.sync_byte       = w_word[31:24];
            o_res.transport_error = w_word[23];
            o_res.unit_start      = w_word[22];
            o_res.priority_bit    = w_word[21];
            o_res.packet_id       = w_word[20:8];
            o_res.scrambling      = w_word[7:6];
            o_res.field_control   = w_word[5:4];
            o_res.continuity      = w_word[3:0];
        end else if (w_pos8 == 8'd4 && r_ctrl[1]) begin
            n_alen = w_sat;
            if (r_ctrl == tspp_pkg::AFC_BOTH) begin
                n_pstart = HDR_BYTES_B + 8'd1 + w_sat;
            end
            // An empty adaptation field is reported here with no flags byte.
            if (w_sat == 8'd0) begin
                o_res_valid = 1'b1;
                o_res.kind  = tspp_pkg::KIND_ADAPT;
            end
        end else if (w_pos8 == 8'd5 && r_ctrl[1] && r_alen != 8'd0) begin
            o_res_valid        = 1'b1;
            o_res.kind         = tspp_pkg::KIND_ADAPT;
            o_res.adapt_length = r_alen;
            o_res.data_byte    = i_byte;
        end else if (w_pos8 >= r_pstart && w_pos8 < PAYLOAD_END_B) begin
            o_res_valid          = 1'b1;
            o_res.kind           = tspp_pkg::KIND_PAYLOAD;
            o_res.data_byte      = i_byte;
            o_res.last_in_packet = (w_pos8 == PAYLOAD_END_B - 8'd1);
        end

        n_pos = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hdr    <= '0;
            r_ctrl   <= '0;
            r_alen   <= '0;
            r_pstart <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_hdr    <= n_hdr;
            r_ctrl   <= n_ctrl;
            r_alen   <= n_alen;
            r_pstart <= n_pstart;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("byte position ran past the packet end");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> w_pos8 >= 8'd3)
        else $error("result formed before the header was complete");

    a_payload_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == tspp_pkg::KIND_PAYLOAD)
            |-> (w_pos8 >= HDR_BYTES_B && w_pos8 < PAYLOAD_END_B))
        else $error("payload byte outside the payload span");

endmodule
`default_nettype wire

// ===== src/tspp_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tspp_out_stage
// Output register with one skid entry, so that input ready depends on
// registered state only.
// ----------------------------------------------------------------------------
module tspp_out_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  tspp_pkg::t_result      i_res,
    output logic                   o_ready,
    output logic                   o_valid,
    output tspp_pkg::t_result      o_res,
    input  wire                    i_ready
);

    logic              r_out_valid;
    logic              r_skid_valid;
    tspp_pkg::t_result r_out;
    tspp_pkg::t_result r_skid;
    logic              w_pop;

    assign w_pop   = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_pop || !r_out_valid) begin
            r_out_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_pop || !r_out_valid) begin
            r_out <= i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_pop) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to the output register");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled output transfer changed before it was taken");

endmodule
`default_nettype wire
